>>> design/ptrc_pkg.sv
// Package for the planar tile to RGBA converter.
// Holds the register index codes, the row hand-off type and the master color table.
// No dependencies.
package ptrc_pkg;

   // Width of the byte position when the bank holds the largest tile count.
   localparam int unsigned POS_FULL_W = 12;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SUB_PAL_0 = 3'd0,
      CSR_SUB_PAL_1 = 3'd1,
      CSR_SUB_PAL_2 = 3'd2,
      CSR_SUB_PAL_3 = 3'd3,
      CSR_PAL_SEL   = 3'd4
   } csr_index_type;

   // One row of a tile, handed from the plane store to the pixel serializer.
   typedef struct packed {
      logic       valid;
      logic [7:0] lo_plane;
      logic [7:0] hi_plane;
      logic [3:0] tile_col;
      logic [6:0] pix_y;
   } row_type;

   localparam logic [31:0] MASTER_ROM [64] = '{
      32'hFF656766, 32'hFF9D1F00, 32'hFFAD0D21, 32'hFF9C0445,
      32'hFF6E036B, 32'hFF1E0372, 32'hFF001165, 32'hFF001F45,
      32'hFF002E23, 32'hFF003900, 32'hFF003D00, 32'hFF213800,
      32'hFF663200, 32'hFF000000, 32'hFF000000, 32'hFF000000,
      32'hFFAFB1B1, 32'hFFEA5508, 32'hFFFF3D47, 32'hFFFE3077,
      32'hFFCE2CAD, 32'hFF642ABD, 32'hFF003AB5, 32'hFF004C8F,
      32'hFF006063, 32'hFF00701B, 32'hFF007700, 32'hFF3C7400,
      32'hFF996D00, 32'hFF000000, 32'hFF000000, 32'hFF000000,
      32'hFFFFFFFF, 32'hFFFFAD4D, 32'hFFFF9587, 32'hFFFF86B9,
      32'hFFFF80F1, 32'hFFD37AFF, 32'hFF5F87FF, 32'hFF1298EF,
      32'hFF00ABC9, 32'hFF00BE7F, 32'hFF20C847, 32'hFF70C82C,
      32'hFFCCC42F, 32'hFF4F5151, 32'hFF000000, 32'hFF000000,
      32'hFFFFFFFF, 32'hFFFFE5BA, 32'hFFFFDBD1, 32'hFFFFD5E6,
      32'hFFFFD2FD, 32'hFFF5CFFF, 32'hFFC5D5FF, 32'hFFA3DBFF,
      32'hFF91E3EF, 32'hFF8FECD0, 32'hFFA6F0B9, 32'hFFC7F0AE,
      32'hFFEEEEAF, 32'hFFBABCBB, 32'hFF000000, 32'hFF000000
   };

endpackage

>>> design/ptrc_plane_store.sv
// Byte position counter and low-plane row store of the tile converter.
// Hands each high-plane row to the pixel serializer. Depends on ptrc_pkg.
module ptrc_plane_store #(
   parameter int unsigned TILE_COUNT = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_chr_byte,
   input  logic             slot_free,
   output ptrc_pkg::row_type row_load
);
   import ptrc_pkg::*;

   localparam int unsigned BYTE_COUNT = TILE_COUNT * 16;
   localparam int unsigned PW         = $clog2(BYTE_COUNT);
   localparam logic [PW-1:0] LAST_POS = PW'(BYTE_COUNT - 1);

   logic [PW-1:0]         pos_ff;
   logic [PW-1:0]         pos_in;
   logic [POS_FULL_W-1:0] pos_ext;
   logic [7:0]            rows_ff [8];
   logic                  is_high;
   logic                  accept;

   assign pos_ext = POS_FULL_W'(pos_ff);
   assign is_high = pos_ff[3];

   // Low-plane bytes only fill the store, so they never wait on the serializer.
   assign req_ready = !is_high || slot_free;
   assign accept    = req_valid && req_ready;
   assign pos_in    = (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;

   always_comb begin
      row_load.valid    = accept && is_high;
      row_load.lo_plane = rows_ff[pos_ff[2:0]];
      row_load.hi_plane = req_chr_byte;
      row_load.tile_col = pos_ext[7:4];
      row_load.pix_y    = {pos_ext[11:8], pos_ext[2:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !is_high) begin
         rows_ff[pos_ff[2:0]] <= req_chr_byte;
      end
   end

`ifndef SYNTH
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && pos_ff == LAST_POS |=> pos_ff == '0)
      else $error("byte position did not wrap at the end of the bank");

   a_stall_high: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> is_high && !slot_free)
      else $error("input stalled on a low-plane byte");
`endif
endmodule

>>> design/ptrc_pixel_serializer.sv
// Row slot and result register of the tile converter: one pixel per cycle while
// not stalled. Looks up the palette byte and master color. Depends on ptrc_pkg.
module ptrc_pixel_serializer (
   input  logic              clock,
   input  logic              reset,
   input  ptrc_pkg::row_type row_load,
   output logic              slot_free,
   input  logic [31:0]       pal_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [6:0]        rsp_pixel_x,
   output logic [6:0]        rsp_pixel_y,
   output logic [31:0]       rsp_color_word,
   output logic              rsp_last_of_run
);
   import ptrc_pkg::*;

   logic        slot_valid_ff;
   logic [7:0]  lo_ff;
   logic [7:0]  hi_ff;
   logic [3:0]  tile_col_ff;
   logic [6:0]  pix_y_ff;
   logic [2:0]  cnt_ff;

   logic        rsp_valid_ff;
   logic [6:0]  rsp_x_ff;
   logic [6:0]  rsp_y_ff;
   logic [31:0] rsp_color_ff;
   logic        rsp_last_ff;

   logic        adv;
   logic        row_done;
   logic [2:0]  bit_sel;
   logic [1:0]  color_id;
   logic [7:0]  pal_byte;

   assign adv       = slot_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign row_done  = adv && (cnt_ff == 3'd7);
   assign slot_free = !slot_valid_ff || row_done;

   // Pixel zero is the most significant bit of both planes.
   assign bit_sel  = ~cnt_ff;
   assign color_id = {hi_ff[bit_sel], lo_ff[bit_sel]};
   assign pal_byte = pal_word[{color_id, 3'b000} +: 8];

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (row_load.valid) begin
            slot_valid_ff <= 1'b1;
            cnt_ff        <= '0;
         end else if (adv) begin
            slot_valid_ff <= !row_done;
            cnt_ff        <= cnt_ff + 1'b1;
         end
         if (adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (row_load.valid) begin
         lo_ff       <= row_load.lo_plane;
         hi_ff       <= row_load.hi_plane;
         tile_col_ff <= row_load.tile_col;
         pix_y_ff    <= row_load.pix_y;
      end
      if (adv) begin
         rsp_x_ff     <= {tile_col_ff, cnt_ff};
         rsp_y_ff     <= pix_y_ff;
         rsp_color_ff <= MASTER_ROM[pal_byte[5:0]];
         rsp_last_ff  <= (cnt_ff == 3'd7);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_color_word  = rsp_color_ff;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef SYNTH
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      row_load.valid |-> slot_free)
      else $error("row loaded while the slot still holds pixels");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_valid_ff && (rsp_last_ff == ($past(cnt_ff) == 3'd7)))
      else $error("end-of-row flag does not match the pixel count");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !slot_valid_ff |-> cnt_ff == 3'd0)
      else $error("pixel count left nonzero in an empty slot");
`endif
endmodule

>>> design/planar_tile_to_rgba_converter.sv
// Top level of the planar tile to RGBA converter: palette registers and block wiring.
// Depends on ptrc_pkg, ptrc_plane_store and ptrc_pixel_serializer.
//
// Feed the tile bank one byte per item in bank order. The eight low-plane bytes of
// a tile are stored and produce nothing; each of the eight high-plane bytes
// produces the eight pixels of its row, leftmost first, one result per cycle while
// the output is not stalled. Low-plane bytes are taken in every cycle. A high-plane
// byte is taken when the single row slot is free or emptying, so the row slot and
// its pixel output set the input rate. The first pixel of a row passes through the
// row slot and then the result register after its byte is taken. The byte
// position wraps to the first byte after byte TILE_COUNT*16-1. Write the palette
// registers only while no pixels are pending.
module planar_tile_to_rgba_converter #(
   parameter int unsigned TILE_COUNT = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_chr_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [6:0]                      rsp_pixel_x,
   output logic [6:0]                      rsp_pixel_y,
   output logic [31:0]                     rsp_color_word,
   output logic                            rsp_last_of_run,
   input  logic                            csr_write_en,
   input  logic [ptrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ptrc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ptrc_pkg::*;

   logic [31:0] sub_pal_ff [4];
   logic [1:0]  pal_sel_ff;
   logic [31:0] pal_word;
   row_type     row_load;
   logic        slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_pal_ff[0] <= '0;
         sub_pal_ff[1] <= '0;
         sub_pal_ff[2] <= '0;
         sub_pal_ff[3] <= '0;
         pal_sel_ff    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SUB_PAL_0: sub_pal_ff[0] <= csr_wdata;
            CSR_SUB_PAL_1: sub_pal_ff[1] <= csr_wdata;
            CSR_SUB_PAL_2: sub_pal_ff[2] <= csr_wdata;
            CSR_SUB_PAL_3: sub_pal_ff[3] <= csr_wdata;
            CSR_PAL_SEL:   pal_sel_ff    <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   assign pal_word = sub_pal_ff[pal_sel_ff];

   ptrc_plane_store #(
      .TILE_COUNT (TILE_COUNT)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_chr_byte (req_chr_byte),
      .slot_free    (slot_free),
      .row_load     (row_load)
   );

   ptrc_pixel_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .row_load        (row_load),
      .slot_free       (slot_free),
      .pal_word        (pal_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_color_word  (rsp_color_word),
      .rsp_last_of_run (rsp_last_of_run)
   );
endmodule
